### design/bp_pkg.sv
// Shared constants, types and command codes of the MSB-first bit packer.
package bp_pkg;

  localparam int STORE_BYTES = 256;
  localparam int STORE_BITS  = STORE_BYTES * 8;
  localparam int CUR_W       = $clog2(STORE_BITS + 1);
  localparam int NUM_WORDS   = (STORE_BYTES + 3) / 4;
  localparam int BANK_DEPTH  = NUM_WORDS / 2 + 1;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int POS_W       = 12;

  typedef enum logic [1:0] {
    CMD_CLEAR       = 2'd0,
    CMD_OR_WRITE    = 2'd1,
    CMD_READ        = 2'd2,
    CMD_EXACT_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_MERGE,
    BK_CLEAR
  } back_state_e;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    cmd_e               cmd;
    logic [31:0]        value;
    logic [5:0]         count;
    logic [5:0]         shift;
    logic               swap;
    logic [BANK_AW-1:0] even_addr;
    logic [BANK_AW-1:0] odd_addr;
    logic               skip;
    logic               overrun;
    logic [POS_W-1:0]   pos;
  } op_t;

  // Access request to one word bank.
  typedef struct packed {
    logic               re;
    logic [BANK_AW-1:0] raddr;
    logic               we;
    logic [BANK_AW-1:0] waddr;
    logic [31:0]        wdata;
  } bank_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### design/bp_ram.sv
// Generic simple dual-port RAM with a registered read port.
module bp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bp_front.sv
// Front end: holds the bit cursor, checks bounds and classifies each command.
module bp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [1:0]    cmd_i,
  input  logic [31:0]   value_i,
  input  logic [5:0]    bit_count_i,
  output bp_pkg::op_t   op_o
);
  import bp_pkg::*;

  localparam int WAW = CUR_W - 5;

  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic [5:0]       count;
  logic [CUR_W:0]   sum;
  logic             ovr;
  logic             skip;
  logic [WAW-1:0]   word;
  logic [WAW:0]     word_p1;
  logic [6:0]       shift_full;
  cmd_e             cmd;

  always_comb begin
    cmd        = cmd_e'(cmd_i);
    count      = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;
    sum        = {1'b0, cursor_q} + (CUR_W + 1)'(count);
    ovr        = (cmd != CMD_CLEAR) && (count != 6'd0) &&
                 (sum > (CUR_W + 1)'(STORE_BITS));
    skip       = ovr || (count == 6'd0);
    word       = cursor_q[CUR_W-1:5];
    word_p1    = {1'b0, word} + (WAW + 1)'(1);
    // The field sits at offset o within a 64-bit pair of words; it is
    // right-aligned by shifting down 64 - o - count bits.
    shift_full = 7'd64 - {2'b00, cursor_q[4:0]} - {1'b0, count};

    if (cmd == CMD_CLEAR) begin
      cursor_d = '0;
    end else if (skip) begin
      cursor_d = cursor_q;
    end else begin
      cursor_d = sum[CUR_W-1:0];
    end

    op_o.cmd       = cmd;
    op_o.value     = value_i;
    op_o.count     = count;
    op_o.shift     = shift_full[5:0];
    op_o.swap      = word[0];
    op_o.even_addr = BANK_AW'(word_p1 >> 1);
    op_o.odd_addr  = BANK_AW'(word >> 1);
    op_o.skip      = skip;
    op_o.overrun   = ovr;
    op_o.pos       = POS_W'(cursor_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (accept_i) begin
      cursor_q <= cursor_d;
    end
  end

endmodule

### design/bp_queue.sv
// Short register FIFO of classified commands between front and back.
module bp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bp_pkg::op_t           op_i,
  input  logic                  pop_i,
  output bp_pkg::op_t           op_o,
  output bp_pkg::queue_status_t status_o
);
  import bp_pkg::*;

  op_t                 slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [QUEUE_AW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= QUEUE_AW'(wptr_q + 1'b1);
      end
      if (pop_i) begin
        rptr_q <= QUEUE_AW'(rptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= op_i;
    end
  end

  assign op_o           = slot_q[rptr_q];
  assign status_o.full  = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

### design/bp_back.sv
// Back end: performs store accesses, clearing sweeps and issues results.
module bp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bp_pkg::op_t           head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output bp_pkg::bank_req_t     even_req_o,
  output bp_pkg::bank_req_t     odd_req_o,
  input  logic [31:0]           even_rdata_i,
  input  logic [31:0]           odd_rdata_i,
  output logic                  init_o,
  output logic                  done_o,
  output logic [31:0]           read_value_o,
  output logic [11:0]           bit_position_o,
  output logic                  overrun_o
);
  import bp_pkg::*;

  back_state_e        state_q, state_d;
  logic [BANK_AW-1:0] cnt_q, cnt_d;
  op_t                op_q, op_d;
  logic               done_q, emit;
  logic [31:0]        rv_q, rv_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               ovr_q, ovr_d;

  logic [63:0] cat, mask64, data64, new_cat;
  logic [31:0] mask32, rd_bits, even_new, odd_new;
  logic        last;

  // Merge path: the two words holding the field form one 64-bit window.
  always_comb begin
    cat      = op_q.swap ? {odd_rdata_i, even_rdata_i} : {even_rdata_i, odd_rdata_i};
    mask32   = 32'((33'd1 << op_q.count) - 33'd1);
    mask64   = {32'd0, mask32} << op_q.shift;
    data64   = {32'd0, op_q.value & mask32} << op_q.shift;
    rd_bits  = 32'(cat >> op_q.shift) & mask32;
    if (op_q.cmd == CMD_EXACT_WRITE) begin
      new_cat = (cat & ~mask64) | data64;
    end else begin
      new_cat = cat | data64;
    end
    even_new = op_q.swap ? new_cat[31:0] : new_cat[63:32];
    odd_new  = op_q.swap ? new_cat[63:32] : new_cat[31:0];
  end

  assign last = (cnt_q == BANK_AW'(BANK_DEPTH - 1));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    op_d       = op_q;
    pop_o      = 1'b0;
    emit       = 1'b0;
    rv_d       = 32'd0;
    pos_d      = op_q.pos;
    ovr_d      = op_q.overrun;
    even_req_o = '0;
    odd_req_o  = '0;

    case (state_q)
      BK_INIT, BK_CLEAR: begin
        even_req_o.we    = 1'b1;
        even_req_o.waddr = cnt_q;
        odd_req_o.we     = 1'b1;
        odd_req_o.waddr  = cnt_q;
        if (last) begin
          state_d = BK_IDLE;
          emit    = (state_q == BK_CLEAR);
          ovr_d   = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          op_d  = head_i;
          if (head_i.cmd == CMD_CLEAR) begin
            cnt_d   = '0;
            state_d = BK_CLEAR;
          end else if (head_i.skip) begin
            emit  = 1'b1;
            pos_d = head_i.pos;
            ovr_d = head_i.overrun;
          end else begin
            even_req_o.re    = 1'b1;
            even_req_o.raddr = head_i.even_addr;
            odd_req_o.re     = 1'b1;
            odd_req_o.raddr  = head_i.odd_addr;
            state_d          = BK_MERGE;
          end
        end
      end
      BK_MERGE: begin
        emit    = 1'b1;
        state_d = BK_IDLE;
        if (op_q.cmd == CMD_READ) begin
          rv_d = rd_bits;
        end else begin
          even_req_o.we    = 1'b1;
          even_req_o.waddr = op_q.even_addr;
          even_req_o.wdata = even_new;
          odd_req_o.we     = 1'b1;
          odd_req_o.waddr  = op_q.odd_addr;
          odd_req_o.wdata  = odd_new;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_INIT;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    if (emit) begin
      rv_q  <= rv_d;
      pos_q <= pos_d;
      ovr_q <= ovr_d;
    end
  end

  assign init_o         = (state_q == BK_INIT);
  assign done_o         = done_q;
  assign read_value_o   = rv_q;
  assign bit_position_o = pos_q;
  assign overrun_o      = ovr_q;

endmodule

### design/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: front, queue, back and two word banks.
// Reads and writes are popped by the back, read from both banks, then finish in BK_MERGE
// (a read takes its bits, a write merges them back); a skipped (overrun or zero-count)
// command gives its result at the pop, a clear after a sweep of all bank words. The
// queue takes commands as the back works; reset sweeps the banks to zero with busy high.
// The receiver cannot stall; each result is shown on done_o for one cycle.
module msb_first_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  bit_count_i,
  output logic        done_o,
  output logic [31:0] read_value_o,
  output logic [11:0] bit_position_o,
  output logic        overrun_o
);
  import bp_pkg::*;

  logic          accept;
  logic          pop;
  logic          init;
  op_t           front_op, head_op;
  queue_status_t qstat;
  bank_req_t     even_req, odd_req;
  logic [31:0]   even_rdata, odd_rdata;

  assign busy   = qstat.full || init;
  assign accept = start && !busy;

  bp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .bit_count_i (bit_count_i),
    .op_o        (front_op)
  );

  bp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .op_i     (front_op),
    .pop_i    (pop),
    .op_o     (head_op),
    .status_o (qstat)
  );

  bp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_op),
    .empty_i        (qstat.empty),
    .pop_o          (pop),
    .even_req_o     (even_req),
    .odd_req_o      (odd_req),
    .even_rdata_i   (even_rdata),
    .odd_rdata_i    (odd_rdata),
    .init_o         (init),
    .done_o         (done_o),
    .read_value_o   (read_value_o),
    .bit_position_o (bit_position_o),
    .overrun_o      (overrun_o)
  );

  bp_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (even_req.we),
    .waddr_i (even_req.waddr),
    .wdata_i (even_req.wdata),
    .re_i    (even_req.re),
    .raddr_i (even_req.raddr),
    .rdata_o (even_rdata)
  );

  bp_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (odd_req.we),
    .waddr_i (odd_req.waddr),
    .wdata_i (odd_req.wdata),
    .re_i    (odd_req.re),
    .raddr_i (odd_req.raddr),
    .rdata_o (odd_rdata)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !qstat.full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

  a_overrun_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overrun_o) |-> (read_value_o == 32'd0))
    else $error("overrun result carries read data");

  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init |-> !done_o)
    else $error("result issued during reset sweep");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the MSB-first bit packer: directed table, then random commands.
module testbench;
  import bp_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int PHASE_ITEMS  = 358;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 40;
  localparam int NUM_ROWS     = 17;

  typedef struct packed {
    logic [31:0] read_value;
    logic [11:0] bit_position;
    logic        overrun;
  } pack_result_t;

  // One directed row; typed rows carry the result written out by hand.
  typedef struct {
    cmd_e         cmd;
    logic [31:0]  value;
    logic [5:0]   count;
    int           reps;
    bit           typed;
    pack_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  cmd_i;
  logic [31:0] value_i;
  logic [5:0]  bit_count_i;
  logic        done_o;
  logic [31:0] read_value_o;
  logic [11:0] bit_position_o;
  logic        overrun_o;

  logic [7:0]   shadow_store [STORE_BYTES];
  int unsigned  shadow_cursor;
  pack_result_t expected_results [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct;

  // The store is filled with 32-bit writes up to 2017, so the next 32-bit access overruns and
  // a 31-bit write then lands exactly on the end of the store.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{CMD_READ,        32'h0000_0000, 6'd32, 1,  1'b1, '{32'd0, 12'd32,   1'b0}},
    '{CMD_CLEAR,       32'hFFFF_FFFF, 6'd63, 1,  1'b1, '{32'd0, 12'd0,    1'b0}},
    '{CMD_OR_WRITE,    32'hFFFF_FFFF, 6'd32, 1,  1'b1, '{32'd0, 12'd32,   1'b0}},
    '{CMD_EXACT_WRITE, 32'h0000_0000, 6'd1,  1,  1'b0, '{32'd0, 12'd0,    1'b0}},
    '{CMD_EXACT_WRITE, 32'hAAAA_AAAA, 6'd0,  1,  1'b0, '{32'd0, 12'd0,    1'b0}},
    '{CMD_OR_WRITE,    32'h8000_0001, 6'd63, 1,  1'b0, '{32'd0, 12'd0,    1'b0}},
    '{CMD_EXACT_WRITE, 32'h1234_5678, 6'd33, 1,  1'b0, '{32'd0, 12'd0,    1'b0}},
    '{CMD_READ,        32'h0000_0000, 6'd48, 1,  1'b0, '{32'd0, 12'd0,    1'b0}},
    '{CMD_OR_WRITE,    32'hFFFF_FFFF, 6'd32, 59, 1'b0, '{32'd0, 12'd0,    1'b0}},
    '{CMD_READ,        32'h0000_0000, 6'd32, 1,  1'b1, '{32'd0, 12'd2017, 1'b1}},
    '{CMD_EXACT_WRITE, 32'h7FFF_FFFF, 6'd31, 1,  1'b0, '{32'd0, 12'd0,    1'b0}},
    '{CMD_READ,        32'h0000_0000, 6'd1,  1,  1'b1, '{32'd0, 12'd2048, 1'b1}},
    '{CMD_OR_WRITE,    32'hFFFF_FFFF, 6'd32, 1,  1'b1, '{32'd0, 12'd2048, 1'b1}},
    '{CMD_READ,        32'h0000_0000, 6'd0,  1,  1'b1, '{32'd0, 12'd2048, 1'b0}},
    '{CMD_CLEAR,       32'h0000_0000, 6'd0,  1,  1'b1, '{32'd0, 12'd0,    1'b0}},
    '{CMD_EXACT_WRITE, 32'hFFFF_FFFF, 6'd32, 1,  1'b0, '{32'd0, 12'd0,    1'b0}},
    '{CMD_READ,        32'h0000_0000, 6'd8,  1,  1'b0, '{32'd0, 12'd0,    1'b0}}
  };

  msb_first_bit_packer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .bit_count_i    (bit_count_i),
    .done_o         (done_o),
    .read_value_o   (read_value_o),
    .bit_position_o (bit_position_o),
    .overrun_o      (overrun_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one command to the shadow store and cursor and returns the result it gives.
  function automatic pack_result_t apply_bit_command(cmd_e cmd, logic [31:0] value,
                                                     logic [5:0] count);
    int unsigned  n;
    int unsigned  pos;
    int unsigned  sh;
    pack_result_t res;
    n = (count > 6'd32) ? 32 : count;
    res = '0;
    if (cmd == CMD_CLEAR) begin
      foreach (shadow_store[b]) shadow_store[b] = 8'h00;
      shadow_cursor = 0;
    end else if (n != 0) begin
      if (shadow_cursor + n > STORE_BYTES * 8) begin
        res.overrun = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) begin
          sh  = n - 1 - i;
          pos = shadow_cursor + i;
          // Bit 0 of the stream is the most significant bit of its byte.
          if (cmd == CMD_READ) begin
            res.read_value[sh] = shadow_store[pos >> 3][7 - (pos & 7)];
          end else if (value[sh]) begin
            shadow_store[pos >> 3][7 - (pos & 7)] = 1'b1;
          end else if (cmd == CMD_EXACT_WRITE) begin
            shadow_store[pos >> 3][7 - (pos & 7)] = 1'b0;
          end
        end
        shadow_cursor += n;
      end
    end
    res.bit_position = shadow_cursor[11:0];
    return res;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] %s", $time, what);
  endtask

  // Presents one command, waits for its transfer and records the result it should give.
  task automatic send_command(cmd_e cmd, logic [31:0] value, logic [5:0] count, bit typed,
                              pack_result_t want);
    pack_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    cmd_i       <= cmd;
    value_i     <= value;
    bit_count_i <= count;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_bit_command(cmd, value, count);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_random_command();
    cmd_e        cmd;
    logic [31:0] value;
    logic [5:0]  count;
    int          pick;
    // Clears are rare so that the cursor often runs into the end of the store.
    cmd = ($urandom_range(999) < 8) ? CMD_CLEAR : cmd_e'($urandom_range(1, 3));
    pick = $urandom_range(9);
    value = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
    pick = $urandom_range(99);
    if (pick < 60) count = 6'($urandom_range(17, 32));
    else if (pick < 88) count = 6'($urandom_range(1, 16));
    else if (pick < 94) count = 6'd0;
    else count = 6'($urandom_range(33, 63));
    send_command(cmd, value, count, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin : result_check
    pack_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: read_value %h bit_position %0d overrun %b",
                                  read_value_o, bit_position_o, overrun_o));
      end else begin
        want = expected_results.pop_front();
        if (read_value_o !== want.read_value)
          report_mismatch($sformatf("read_value %h, expected %h", read_value_o,
                                    want.read_value));
        if (bit_position_o !== want.bit_position)
          report_mismatch($sformatf("bit_position %0d, expected %0d", bit_position_o,
                                    want.bit_position));
        if (overrun_o !== want.overrun)
          report_mismatch($sformatf("overrun %b, expected %b", overrun_o, want.overrun));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("msb_first_bit_packer: mismatch");
      $finish;
    end
  end

  initial begin
    int idle_pct [3] = '{18, 73, 0};
    rst_ni        = 1'b0;
    start         = 1'b0;
    cmd_i         = CMD_CLEAR;
    value_i       = '0;
    bit_count_i   = '0;
    send_idle_pct = idle_pct[0];
    foreach (shadow_store[b]) shadow_store[b] = 8'h00;
    shadow_cursor = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_command(directed_rows[r].cmd, directed_rows[r].value, directed_rows[r].count,
                     directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = idle_pct[phase];
      for (int k = 0; k < PHASE_ITEMS; k++) send_random_command();
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("msb_first_bit_packer: match");
    end else begin
      $display("msb_first_bit_packer: mismatch");
    end
    $finish;
  end

endmodule

### msb_first_bit_packer.f
design/bp_pkg.sv
design/bp_ram.sv
design/bp_front.sv
design/bp_queue.sv
design/bp_back.sv
design/msb_first_bit_packer.sv
tb/testbench.sv
